@@ design/liaap_pkg.sv @@
`timescale 1ns / 1ps
package liaap_pkg;
    localparam int MAX_COUNT_D    = 65535;
    localparam int SAMPLE_BITS_D  = 32;
    localparam int CORDIC_STEPS_D = 16;
    localparam int SUM_W          = 48;
    localparam int STEP_W         = 52;
    localparam logic [15:0] MIN_COUNT_RST = 16'd50;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd43142465;
            5'd5:  r = 32'd21353441;
            5'd6:  r = 32'd10681886;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic acc;
        logic clr;
        logic div_start;
        logic sq_start;
        logic ph_start;
        logic rt_start;
        logic ms_start;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sq_done;
        logic ph_done;
        logic rt_done;
        logic ms_done;
        logic report_ok;
    } t_sts;
endpackage

@@ design/lockin_average_amplitude_phase_top.sv @@
`timescale 1ns / 1ps
// A sample beat is taken only while idle and leaves busy low, one beat per cycle while busy is low.
// A report beat runs the mean divide, the square root, the phase normalize and
// CORDIC rotation, the ratio divide, the step divide and the output state
// before its result strobes; busy is high until the strobe cycle.
// A report below min_count or with no samples gives no result; the receiver cannot stall.
// Synchronous active-low reset clears sums, count, controller; min_count = 50.
module lockin_average_amplitude_phase_top #(
    parameter int MAX_COUNT    = liaap_pkg::MAX_COUNT_D,
    parameter int SAMPLE_BITS  = liaap_pkg::SAMPLE_BITS_D,
    parameter int CORDIC_STEPS = liaap_pkg::CORDIC_STEPS_D
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic signed [31:0] i_ch0_cos,
    input  logic signed [31:0] i_ch0_sin,
    input  logic signed [31:0] i_ch1_cos,
    input  logic signed [31:0] i_ch1_sin,
    input  logic [63:0]        i_phase_step,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output logic               o_strobe,
    output logic [31:0]        o_ch0_amp,
    output logic signed [15:0] o_ch0_phase,
    output logic [31:0]        o_ch1_amp,
    output logic signed [15:0] o_ch1_phase,
    output logic [23:0]        o_mag_ratio,
    output logic signed [15:0] o_phase_diff,
    output logic [31:0]        o_mean_step,
    output logic [15:0]        o_samples_used
);
    liaap_pkg::t_cmd w_cmd;
    liaap_pkg::t_sts w_sts;
    logic [15:0] r_min_count;
    logic        r_strobe;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_min_count <= liaap_pkg::MIN_COUNT_RST;
        else if (i_cfg_valid) r_min_count <= i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else          r_strobe <= w_cmd.emit;
    end
    assign o_strobe = r_strobe;

    liaap_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_op(i_op),
        .i_sts(w_sts), .o_busy(busy), .o_cmd(w_cmd)
    );

    liaap_dp #(
        .MAX_COUNT(MAX_COUNT), .SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_min_count(r_min_count),
        .i_ch0_cos(i_ch0_cos), .i_ch0_sin(i_ch0_sin),
        .i_ch1_cos(i_ch1_cos), .i_ch1_sin(i_ch1_sin),
        .i_phase_step(i_phase_step),
        .o_ch0_amp(o_ch0_amp), .o_ch0_phase(o_ch0_phase),
        .o_ch1_amp(o_ch1_amp), .o_ch1_phase(o_ch1_phase),
        .o_mag_ratio(o_mag_ratio), .o_phase_diff(o_phase_diff),
        .o_mean_step(o_mean_step), .o_samples_used(o_samples_used)
    );
endmodule

@@ design/liaap_ctrl.sv @@
`timescale 1ns / 1ps
module liaap_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_op,
    input  liaap_pkg::t_sts      i_sts,
    output logic                 o_busy,
    output liaap_pkg::t_cmd      o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_SQ   = 7'b0000100,
        S_PH   = 7'b0001000,
        S_RT   = 7'b0010000,
        S_MS   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && !i_op) o_cmd.acc = 1'b1;
                if (i_start && i_op && i_sts.report_ok) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: if (i_sts.div_done) begin
                o_cmd.sq_start = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: if (i_sts.sq_done) begin
                o_cmd.ph_start = 1'b1;
                n_state = S_PH;
            end
            S_PH: if (i_sts.ph_done) begin
                o_cmd.rt_start = 1'b1;
                n_state = S_RT;
            end
            S_RT: if (i_sts.rt_done) begin
                o_cmd.ms_start = 1'b1;
                n_state = S_MS;
            end
            S_MS: if (i_sts.ms_done) n_state = S_OUT;
            S_OUT: begin
                o_cmd.emit = 1'b1;
                o_cmd.clr  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_emit_from_ms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> $past(r_state) == S_MS)
        else $error("emit without finishing");
    a_idle_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |=> r_state == S_IDLE)
        else $error("out not one cycle");
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc |-> r_state == S_IDLE)
        else $error("accumulate while busy");
`endif
endmodule

@@ design/liaap_dp.sv @@
`timescale 1ns / 1ps
module liaap_dp #(
    parameter int MAX_COUNT    = liaap_pkg::MAX_COUNT_D,
    parameter int SAMPLE_BITS  = liaap_pkg::SAMPLE_BITS_D,
    parameter int CORDIC_STEPS = liaap_pkg::CORDIC_STEPS_D
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  liaap_pkg::t_cmd    i_cmd,
    output liaap_pkg::t_sts    o_sts,
    input  logic [15:0]        i_min_count,
    input  logic signed [31:0] i_ch0_cos,
    input  logic signed [31:0] i_ch0_sin,
    input  logic signed [31:0] i_ch1_cos,
    input  logic signed [31:0] i_ch1_sin,
    input  logic [63:0]        i_phase_step,
    output logic [31:0]        o_ch0_amp,
    output logic signed [15:0] o_ch0_phase,
    output logic [31:0]        o_ch1_amp,
    output logic signed [15:0] o_ch1_phase,
    output logic [23:0]        o_mag_ratio,
    output logic signed [15:0] o_phase_diff,
    output logic [31:0]        o_mean_step,
    output logic [15:0]        o_samples_used
);
    localparam int SW = liaap_pkg::SUM_W;
    localparam int TW = liaap_pkg::STEP_W;
    localparam logic [15:0] MAXC = 16'(MAX_COUNT);

    logic signed [SW-1:0] r_sum [4];
    logic [TW-1:0] r_sstep;
    logic [15:0]   r_cnt;

    logic signed [SW-1:0] w_smp [4];
    assign w_smp[0] = SW'($signed(i_ch0_cos[SAMPLE_BITS-1:0]));
    assign w_smp[1] = SW'($signed(i_ch0_sin[SAMPLE_BITS-1:0]));
    assign w_smp[2] = SW'($signed(i_ch1_cos[SAMPLE_BITS-1:0]));
    assign w_smp[3] = SW'($signed(i_ch1_sin[SAMPLE_BITS-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            for (int k = 0; k < 4; k++) r_sum[k] <= '0;
            r_sstep <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.acc && r_cnt < MAXC) begin
            for (int k = 0; k < 4; k++) r_sum[k] <= r_sum[k] + w_smp[k];
            r_sstep <= r_sstep + TW'(i_phase_step[63:30]);
            r_cnt   <= r_cnt + 16'd1;
        end
    end

    assign o_sts.report_ok = (r_cnt != 16'd0) && (r_cnt >= i_min_count);

    // means: restoring division of |sum| by count, 4 lanes, one bit a cycle
    logic [SW-1:0] r_q [4];
    logic [16:0]   r_rm [4];
    logic [3:0]    r_neg;
    logic [5:0]    r_dcnt;
    logic          r_dbusy;
    logic signed [SW-1:0] r_mean [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= 6'(SW);
            for (int k = 0; k < 4; k++) begin
                r_neg[k] <= r_sum[k][SW-1];
                r_q[k]   <= r_sum[k][SW-1] ? -r_sum[k] : r_sum[k];
                r_rm[k]  <= '0;
            end
        end else if (r_dbusy) begin
            if (r_dcnt == 6'd0) begin
                r_dbusy <= 1'b0;
                for (int k = 0; k < 4; k++)
                    r_mean[k] <= r_neg[k] ? -$signed(r_q[k]) : $signed(r_q[k]);
            end else begin
                r_dcnt <= r_dcnt - 6'd1;
                for (int k = 0; k < 4; k++) begin
                    if ({r_rm[k][15:0], r_q[k][SW-1]} >= {1'b0, r_cnt}) begin
                        r_rm[k] <= {r_rm[k][15:0], r_q[k][SW-1]} - {1'b0, r_cnt};
                        r_q[k]  <= {r_q[k][SW-2:0], 1'b1};
                    end else begin
                        r_rm[k] <= {r_rm[k][15:0], r_q[k][SW-1]};
                        r_q[k]  <= {r_q[k][SW-2:0], 1'b0};
                    end
                end
            end
        end
    end
    assign o_sts.div_done = r_dbusy && r_dcnt == 6'd0;

    // amplitude: squares over cycles then bit-pair square root, per channel
    logic [1:0]  r_sqph;
    logic        r_sqbusy;
    logic [5:0]  r_sqi;
    logic [63:0] r_rad [2];
    logic [63:0] r_res [2];
    logic [63:0] r_bit [2];
    logic [31:0] r_amp [2];
    logic [SW-1:0] w_abs [4];
    always_comb
        for (int k = 0; k < 4; k++)
            w_abs[k] = r_mean[k][SW-1] ? SW'(-r_mean[k]) : SW'(r_mean[k]);

    // squares split into 32x32-or-less partial products in one phase, summed in the next
    logic [31:0] w_mlo [4];
    logic [15:0] w_mhi [4];
    logic [63:0] r_pll [4];
    logic [63:0] r_plh [4];
    logic [31:0] r_phh [4];
    always_comb
        for (int k = 0; k < 4; k++) begin
            w_mlo[k] = w_abs[k][31:0];
            w_mhi[k] = w_abs[k][47:32];
        end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqbusy <= 1'b0;
        end else if (i_cmd.sq_start) begin
            r_sqbusy <= 1'b1;
            r_sqph   <= 2'd0;
        end else if (r_sqbusy) begin
            unique case (r_sqph)
                2'd0: begin
                    for (int k = 0; k < 4; k++) begin
                        r_pll[k] <= w_mlo[k] * w_mlo[k];
                        r_plh[k] <= 64'(w_mlo[k] * 48'(w_mhi[k]));
                        r_phh[k] <= 32'(w_mhi[k] * w_mhi[k]);
                    end
                    r_sqph <= 2'd1;
                end
                2'd1: begin
                    for (int j = 0; j < 2; j++) begin
                        r_rad[j] <= r_pll[2*j] + (r_plh[2*j] << 33) + (64'(r_phh[2*j]) << 64-0)
                                  + r_pll[2*j+1] + (r_plh[2*j+1] << 33);
                        r_res[j] <= '0;
                        r_bit[j] <= 64'h4000_0000_0000_0000;
                    end
                    r_sqi  <= 6'd32;
                    r_sqph <= 2'd2;
                end
                2'd2: begin
                    if (r_sqi == 6'd0) begin
                        for (int j = 0; j < 2; j++)
                            r_amp[j] <= (r_res[j][63:32] != 0) ? 32'hFFFF_FFFF
                                                              : r_res[j][31:0];
                        r_sqph <= 2'd3;
                    end else begin
                        r_sqi <= r_sqi - 6'd1;
                        for (int j = 0; j < 2; j++) begin
                            if (r_rad[j] >= r_res[j] + r_bit[j]) begin
                                r_rad[j] <= r_rad[j] - (r_res[j] + r_bit[j]);
                                r_res[j] <= (r_res[j] >> 1) + r_bit[j];
                            end else begin
                                r_res[j] <= r_res[j] >> 1;
                            end
                            r_bit[j] <= r_bit[j] >> 2;
                        end
                    end
                end
                2'd3: r_sqbusy <= 1'b0;
                default: r_sqbusy <= 1'b0;
            endcase
        end
    end
    assign o_sts.sq_done = r_sqbusy && r_sqph == 2'd3;

    // phase: normalize one bit a cycle, then CORDIC one step a cycle
    localparam int CW = 66;
    logic [1:0]  r_pph;
    logic        r_pbusy;
    logic [4:0]  r_pi;
    logic signed [CW-1:0] r_x [2];
    logic signed [CW-1:0] r_y [2];
    logic signed [CW-1:0] r_z [2];
    logic [1:0]  r_nd;
    logic [15:0] r_phase [2];
    logic [CW-1:0] w_ax [2];
    logic [CW-1:0] w_ay [2];
    logic [CW-1:0] w_m  [2];
    logic [CW-1:0] w_u  [2];
    localparam logic signed [CW-1:0] PI_Z = CW'(64'sd1 <<< 31);

    always_comb
        for (int j = 0; j < 2; j++) begin
            w_ax[j] = r_x[j][CW-1] ? CW'(-r_x[j]) : CW'(r_x[j]);
            w_ay[j] = r_y[j][CW-1] ? CW'(-r_y[j]) : CW'(r_y[j]);
            w_m[j]  = (w_ay[j] > w_ax[j]) ? w_ay[j] : w_ax[j];
            w_u[j]  = CW'(r_z[j] + (CW'(1) <<< 40) + CW'(32768)) >> 16;
        end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbusy <= 1'b0;
        end else if (i_cmd.ph_start) begin
            r_pbusy <= 1'b1;
            r_pph   <= 2'd0;
            r_nd    <= '0;
            for (int j = 0; j < 2; j++) begin
                r_y[j] <= CW'(r_mean[2*j]);
                r_x[j] <= CW'(r_mean[2*j+1]);
                r_z[j] <= '0;
            end
        end else if (r_pbusy) begin
            unique case (r_pph)
                2'd0: begin
                    for (int j = 0; j < 2; j++)
                        if (w_m[j] != 0 && w_m[j] < (CW'(1) << 30)) begin
                            r_x[j] <= r_x[j] <<< 1;
                            r_y[j] <= r_y[j] <<< 1;
                        end
                    if (!((w_m[0] != 0 && w_m[0] < (CW'(1) << 30)) ||
                          (w_m[1] != 0 && w_m[1] < (CW'(1) << 30)))) begin
                        for (int j = 0; j < 2; j++) begin
                            r_nd[j] <= (w_m[j] == 0);
                            if (r_x[j][CW-1]) begin
                                r_z[j] <= r_y[j][CW-1] ? -PI_Z : PI_Z;
                                r_x[j] <= -r_x[j];
                                r_y[j] <= -r_y[j];
                            end
                        end
                        r_pi  <= '0;
                        r_pph <= 2'd1;
                    end
                end
                2'd1: begin
                    for (int j = 0; j < 2; j++) begin
                        if (r_y[j] > 0) begin
                            r_x[j] <= r_x[j] + (r_y[j] >>> r_pi);
                            r_y[j] <= r_y[j] - (r_x[j] >>> r_pi);
                            r_z[j] <= r_z[j] + CW'(liaap_pkg::atan_entry(r_pi));
                        end else begin
                            r_x[j] <= r_x[j] - (r_y[j] >>> r_pi);
                            r_y[j] <= r_y[j] + (r_x[j] >>> r_pi);
                            r_z[j] <= r_z[j] - CW'(liaap_pkg::atan_entry(r_pi));
                        end
                    end
                    if (r_pi == 5'(CORDIC_STEPS - 1)) r_pph <= 2'd2;
                    else r_pi <= r_pi + 5'd1;
                end
                2'd2: begin
                    for (int j = 0; j < 2; j++)
                        r_phase[j] <= r_nd[j] ? 16'd0 : w_u[j][15:0];
                    r_pph <= 2'd3;
                end
                2'd3: r_pbusy <= 1'b0;
                default: r_pbusy <= 1'b0;
            endcase
        end
    end
    assign o_sts.ph_done = r_pbusy && r_pph == 2'd3;

    // ratio: (a1 << 16) / a0, 48-bit restoring division
    logic        r_rbusy;
    logic [5:0]  r_ri;
    logic [47:0] r_rq;
    logic [32:0] r_rr;
    logic [23:0] r_ratio;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rbusy <= 1'b0;
        end else if (i_cmd.rt_start) begin
            r_rbusy <= 1'b1;
            r_ri    <= 6'd48;
            r_rq    <= {r_amp[1], 16'd0};
            r_rr    <= '0;
        end else if (r_rbusy && r_ri != 6'd0) begin
            r_ri <= r_ri - 6'd1;
            if ({r_rr[31:0], r_rq[47]} >= {1'b0, r_amp[0]}) begin
                r_rr <= {r_rr[31:0], r_rq[47]} - {1'b0, r_amp[0]};
                r_rq <= {r_rq[46:0], 1'b1};
            end else begin
                r_rr <= {r_rr[31:0], r_rq[47]};
                r_rq <= {r_rq[46:0], 1'b0};
            end
        end else if (r_rbusy) begin
            r_rbusy <= 1'b0;
            r_ratio <= (r_amp[0] == 0) ? 24'd0
                     : (r_rq[47:24] != 0) ? 24'hFF_FFFF : r_rq[23:0];
        end
    end
    assign o_sts.rt_done = r_rbusy && r_ri == 6'd0;

    // mean step: sum_step / (4*count) = (sum_step >> 2) / count
    logic        r_mbusy;
    logic [5:0]  r_mi;
    logic [TW-3:0] r_mq;
    logic [16:0] r_mr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (i_cmd.ms_start) begin
            r_mbusy <= 1'b1;
            r_mi    <= 6'(TW - 2);
            r_mq    <= r_sstep[TW-1:2];
            r_mr    <= '0;
        end else if (r_mbusy && r_mi != 6'd0) begin
            r_mi <= r_mi - 6'd1;
            if ({r_mr[15:0], r_mq[TW-3]} >= {1'b0, r_cnt}) begin
                r_mr <= {r_mr[15:0], r_mq[TW-3]} - {1'b0, r_cnt};
                r_mq <= {r_mq[TW-4:0], 1'b1};
            end else begin
                r_mr <= {r_mr[15:0], r_mq[TW-3]};
                r_mq <= {r_mq[TW-4:0], 1'b0};
            end
        end else if (r_mbusy) begin
            r_mbusy <= 1'b0;
        end
    end
    assign o_sts.ms_done = r_mbusy && r_mi == 6'd0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_ch0_amp      <= r_amp[0];
            o_ch1_amp      <= r_amp[1];
            o_ch0_phase    <= r_phase[0];
            o_ch1_phase    <= r_phase[1];
            o_mag_ratio    <= r_ratio;
            o_phase_diff   <= r_phase[0] - r_phase[1];
            o_mean_step    <= r_mq[31:0];
            o_samples_used <= r_cnt;
        end
    end
endmodule
